FILE: rtl/core/mlsd_pkg.sv
// Shared constants and types for the masked 3x3 local standard deviation block.
`timescale 1ns / 1ps
`default_nettype none

package mlsd_pkg;

  localparam int Radius  = 1;
  localparam int WinSide = 2 * Radius + 1;
  localparam int WinN    = WinSide * WinSide;

  localparam int PIX_W  = 16;
  localparam int SUM_W  = 20;   // signed sum of nine samples
  localparam int ABS_W  = 19;   // magnitude of that sum
  localparam int SQ_W   = 31;   // one square, at most 2^30
  localparam int Q_W    = 34;   // sum of nine squares
  localparam int A_W    = 17;   // |S| / 3
  localparam int A2_W   = 34;
  localparam int T_W    = 26;
  localparam int U_W    = 23;
  localparam int RAD_W  = 40;   // radicand 256 * variance
  localparam int ROOT_W = 20;
  localparam int REM_W  = 21;
  localparam int OUT_W  = 20;

  localparam int DATA_IN_W  = WinN * PIX_W;
  localparam int DATA_OUT_W = ((OUT_W + 7) / 8) * 8;

  // ceil(2^19 / 3): exact quotient for any 19-bit dividend.
  localparam logic [17:0] RECIP3 = 18'd174763;
  // ceil(2^30 / 9): exact quotient for any dividend below 2^27.
  localparam logic [26:0] RECIP9 = 27'd119304648;

  // Residue of |S| modulo three.
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_ONE  = 2'd1;
  localparam logic [1:0] RES_TWO  = 2'd2;

  // Partial state of the square root handed from one cell to the next.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/masked_local_std_dev_3x3.sv
// Top level of the masked 3x3 local standard deviation filter.
//
//  Channel   Dir  Signals                    Contents
//  s_axis    in   s_tvalid/s_tready/s_tdata  nine signed 16-bit samples, s_tuser = inside_mask
//  m_axis    out  m_tvalid/m_tready/m_tdata  std_scaled, 20-bit unsigned, 4 fraction bits
//
// One transaction is accepted per cycle unless a stalled output fills the pipeline;
// each result passes six front stages and then one square root cell per result bit.
// Every stage holds its own valid bit, so bubbles close up and new windows are
// taken while finished results wait on m_tready. Reset is synchronous and
// clears only valid bits.
`timescale 1ns / 1ps
`default_nettype none

module masked_local_std_dev_3x3 (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // win_0 .. win_8, 16 bits each, win_0 in the lowest bits
  input  wire [mlsd_pkg::DATA_IN_W-1:0]       s_tdata,
  // inside_mask
  input  wire                                 s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // std_scaled in bits 19:0, upper bits zero
  output logic [mlsd_pkg::DATA_OUT_W-1:0]     m_tdata
);

  localparam int NCell = mlsd_pkg::ROOT_W;

  logic signed [mlsd_pkg::PIX_W-1:0] win [mlsd_pkg::WinN];
  logic                              front_valid;
  logic                              front_ready;
  logic [mlsd_pkg::RAD_W-1:0]        front_rad;

  logic                  cell_in_valid  [NCell];
  logic                  cell_in_ready  [NCell];
  mlsd_pkg::sqrt_state_t cell_in_data   [NCell];
  logic                  cell_out_valid [NCell];
  logic                  cell_out_ready [NCell];
  mlsd_pkg::sqrt_state_t cell_out_data  [NCell];

  always_comb begin
    for (int i = 0; i < mlsd_pkg::WinN; i++) begin
      win[i] = s_tdata[i*mlsd_pkg::PIX_W +: mlsd_pkg::PIX_W];
    end
  end

  mlsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .win         (win),
    .inside_mask (s_tuser),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .rad         (front_rad)
  );

  assign cell_in_valid[0]     = front_valid;
  assign cell_in_data[0].rem  = '0;
  assign cell_in_data[0].root = '0;
  assign cell_in_data[0].rad  = front_rad;
  assign front_ready          = cell_in_ready[0];

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign cell_in_valid[g]    = cell_out_valid[g-1];
      assign cell_in_data[g]     = cell_out_data[g-1];
      assign cell_out_ready[g-1] = cell_in_ready[g];
    end
    mlsd_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_in_valid[g]),
      .in_ready  (cell_in_ready[g]),
      .in_data   (cell_in_data[g]),
      .out_valid (cell_out_valid[g]),
      .out_ready (cell_out_ready[g]),
      .out_data  (cell_out_data[g])
    );
  end

  assign cell_out_ready[NCell-1] = m_tready;
  assign m_tvalid = cell_out_valid[NCell-1];
  assign m_tdata  = mlsd_pkg::DATA_OUT_W'(cell_out_data[NCell-1].root);

`ifndef SYNTHESIS
  // The radicand is below 2^39 for every window.
  a_rad_range: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> !front_rad[mlsd_pkg::RAD_W-1])
    else $error("radicand out of range");

  // A finished root leaves a remainder of at most twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cell_out_data[NCell-1].rem <= {cell_out_data[NCell-1].root, 1'b0}))
    else $error("square root remainder too large");

  // Input back-pressure only arises from a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output stall");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mlsd_front.sv
// Pipeline that turns one window into the radicand floor(256 * (9Q - S^2) / 72).
`timescale 1ns / 1ps
`default_nettype none

module mlsd_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [mlsd_pkg::PIX_W-1:0]    win [mlsd_pkg::WinN],
  input  wire                                 inside_mask,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mlsd_pkg::RAD_W-1:0]          rad
);

  localparam int NStage = 6;

  logic [NStage-1:0] vld;
  logic [NStage-1:0] en;

  logic [mlsd_pkg::SQ_W-1:0]         st1_sq [mlsd_pkg::WinN];
  logic signed [mlsd_pkg::SUM_W-1:0] st1_s;
  logic [mlsd_pkg::Q_W-1:0]          st2_q;
  logic [mlsd_pkg::ABS_W-1:0]        st2_s_abs;
  logic [mlsd_pkg::Q_W-1:0]          st3_q;
  logic [mlsd_pkg::A_W-1:0]          st3_a;
  logic [mlsd_pkg::ABS_W-1:0]        st3_s_abs;
  logic [mlsd_pkg::Q_W-1:0]          st4_q;
  logic [mlsd_pkg::A2_W-1:0]         st4_a2;
  logic [mlsd_pkg::T_W-1:0]          st4_t;
  logic [mlsd_pkg::Q_W-1:0]          st5_q;
  logic [mlsd_pkg::A2_W-1:0]         st5_a2;
  logic [mlsd_pkg::U_W-1:0]          st5_u;

  logic [mlsd_pkg::SQ_W-1:0]         sq_next [mlsd_pkg::WinN];
  logic signed [mlsd_pkg::SUM_W-1:0] s_next;
  logic [mlsd_pkg::Q_W-1:0]          q_next;
  logic [mlsd_pkg::ABS_W-1:0]        s_abs_next;
  logic [mlsd_pkg::ABS_W+17:0]       a_prod;
  logic [mlsd_pkg::ABS_W-1:0]        three_a;
  logic [mlsd_pkg::ABS_W-1:0]        res_full;
  logic [1:0]                        res;
  logic [mlsd_pkg::T_W-1:0]          a_ext;
  logic [mlsd_pkg::T_W-1:0]          t_next;
  logic [mlsd_pkg::T_W+26:0]         u_prod;
  logic [mlsd_pkg::RAD_W-1:0]        rad_next;

  // A stage takes new data when it is empty or its successor takes its data.
  always_comb begin
    en[NStage-1] = !vld[NStage-1] || out_ready;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NStage-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = NStage - 1; k > 0; k--) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (en[0]) begin
        vld[0] <= in_valid;
      end
    end
  end

  // Stage 1: squares and plain sum; a sample outside the mask becomes a flat zero window.
  always_comb begin
    s_next = '0;
    for (int i = 0; i < mlsd_pkg::WinN; i++) begin
      sq_next[i] = inside_mask ? mlsd_pkg::SQ_W'(unsigned'(32'(win[i]) * 32'(win[i]))) : '0;
      s_next     = s_next + (inside_mask ? mlsd_pkg::SUM_W'(win[i]) : '0);
    end
  end

  // Stage 2: sum of squares and |S|.
  always_comb begin
    q_next = '0;
    for (int i = 0; i < mlsd_pkg::WinN; i++) begin
      q_next = q_next + mlsd_pkg::Q_W'(st1_sq[i]);
    end
    s_abs_next = st1_s[mlsd_pkg::SUM_W-1] ? mlsd_pkg::ABS_W'(-st1_s)
                                          : mlsd_pkg::ABS_W'(st1_s);
  end

  // Stage 3: a = |S| / 3.
  assign a_prod = st2_s_abs * mlsd_pkg::RECIP3;

  // Stage 4: with |S| = 3a + r, 32 S^2 / 9 = 32 a^2 + (192 a r + 32 r^2) / 9.
  always_comb begin
    three_a  = mlsd_pkg::ABS_W'({st3_a, 1'b0}) + mlsd_pkg::ABS_W'(st3_a);
    res_full = st3_s_abs - three_a;
    res      = res_full[1:0];
    a_ext    = mlsd_pkg::T_W'(st3_a);
    case (res)
      mlsd_pkg::RES_ZERO: t_next = '0;
      mlsd_pkg::RES_ONE:  t_next = (a_ext << 7) + (a_ext << 6) + mlsd_pkg::T_W'(32);
      mlsd_pkg::RES_TWO:  t_next = (a_ext << 8) + (a_ext << 7) + mlsd_pkg::T_W'(128);
      default:            t_next = '0;
    endcase
  end

  // Stage 5: u = ceil(t / 9) = floor((t + 8) / 9).
  assign u_prod = (st4_t + mlsd_pkg::T_W'(8)) * mlsd_pkg::RECIP9;

  // Stage 6: floor(32 D / 9) = 32 Q - ceil(32 S^2 / 9), never negative.
  assign rad_next = mlsd_pkg::RAD_W'({st5_q, 5'b0}) - mlsd_pkg::RAD_W'({st5_a2, 5'b0})
                    - mlsd_pkg::RAD_W'(st5_u);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st1_sq <= sq_next;
      st1_s  <= s_next;
    end
    if (en[1]) begin
      st2_q     <= q_next;
      st2_s_abs <= s_abs_next;
    end
    if (en[2]) begin
      st3_q     <= st2_q;
      st3_a     <= a_prod[mlsd_pkg::A_W+18:19];
      st3_s_abs <= st2_s_abs;
    end
    if (en[3]) begin
      st4_q  <= st3_q;
      st4_a2 <= mlsd_pkg::A2_W'(st3_a * st3_a);
      st4_t  <= t_next;
    end
    if (en[4]) begin
      st5_q  <= st4_q;
      st5_a2 <= st4_a2;
      st5_u  <= u_prod[mlsd_pkg::U_W+29:30];
    end
    if (en[5]) begin
      rad <= rad_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mlsd_sqrt_cell.sv
// One cell of the square root chain: settles one result bit from two radicand bits.
`timescale 1ns / 1ps
`default_nettype none

module mlsd_sqrt_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  mlsd_pkg::sqrt_state_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output mlsd_pkg::sqrt_state_t out_data
);

  logic                         vld;
  logic [mlsd_pkg::REM_W+1:0]   cur;
  logic [mlsd_pkg::REM_W+1:0]   trial;
  mlsd_pkg::sqrt_state_t        data_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // The remainder stays at most twice the partial root, so it never outgrows REM_W.
  always_comb begin
    cur   = {in_data.rem, in_data.rad[mlsd_pkg::RAD_W-1 -: 2]};
    trial = (mlsd_pkg::REM_W + 2)'({in_data.root, 2'b01});
    data_next.rad = {in_data.rad[mlsd_pkg::RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      data_next.rem  = mlsd_pkg::REM_W'(cur - trial);
      data_next.root = {in_data.root[mlsd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem  = cur[mlsd_pkg::REM_W-1:0];
      data_next.root = {in_data.root[mlsd_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire
